### hw/rtl/dlb_pkg.sv
`timescale 1ns / 1ps
package dlb_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STEP_W   = 17;
  localparam int unsigned EPOCH_W  = 8;
  localparam logic [STEP_W-1:0] SEARCH_HI = 17'd65536;
  localparam logic [WORD_W-1:0] HASH_MULT = 32'd2654435761;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDB,
    ST_REDY,
    ST_SRCH,
    ST_EPOCH,
    ST_HPROD,
    ST_HASH,
    ST_RD,
    ST_CHK,
    ST_BMUL,
    ST_PWCHK,
    ST_PWMUL,
    ST_PWSQ,
    ST_GMUL,
    ST_EXP,
    ST_OUT
  } dlb_state_e;

endpackage

### hw/rtl/dlb_modmul.sv
`timescale 1ns / 1ps
module dlb_modmul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       go_i,
  input  logic [dlb_pkg::WORD_W-1:0] a_i,
  input  logic [dlb_pkg::WORD_W-1:0] b_i,
  input  logic [dlb_pkg::WORD_W-1:0] m_i,
  output logic                       done_o,
  output logic [dlb_pkg::WORD_W-1:0] res_o
);
  import dlb_pkg::*;

  logic                act_q, act_d;
  logic                done_q, done_d;
  logic [4:0]          cnt_q, cnt_d;
  logic [WORD_W-1:0]   a_q, a_d, b_q, b_d, m_q, m_d, r_q, r_d;
  logic [WORD_W+1:0]   t, m1, m2;

  // one multiplier bit per cycle, MSB first; a < m keeps t below 3m
  always_comb begin
    act_d  = act_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    m_d    = m_q;
    r_d    = r_q;
    m1     = {2'b00, m_q};
    m2     = {1'b0, m_q, 1'b0};
    t      = {1'b0, r_q, 1'b0} + (b_q[WORD_W-1] ? {2'b00, a_q} : '0);
    if (go_i) begin
      act_d = 1'b1;
      cnt_d = 5'd31;
      a_d   = a_i;
      b_d   = b_i;
      m_d   = m_i;
      r_d   = '0;
    end else if (act_q) begin
      if (t >= m2) begin
        r_d = WORD_W'(t - m2);
      end else if (t >= m1) begin
        r_d = WORD_W'(t - m1);
      end else begin
        r_d = WORD_W'(t);
      end
      b_d   = {b_q[WORD_W-2:0], 1'b0};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        act_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      act_q  <= act_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    m_q <= m_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign res_o  = r_q;

endmodule

### hw/rtl/dlb_table.sv
`timescale 1ns / 1ps
module dlb_table #(
  parameter int unsigned DEPTH = 131072,
  parameter int unsigned AW    = 17,
  parameter int unsigned DW    = 56
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/discrete_log_bsgs_unit.sv
`timescale 1ns / 1ps
// Channel    | Signals                          | Transfer
// query in   | start, busy, base_i, target_i    | start & !busy
// result out | done_o, found_o, exponent_o      | done_o, one cycle, no stall
// config     | cfg_we_i, cfg_wdata_i            | cfg_we_i (modulus)
// One query at a time; busy stays high until the result cycle ends.
// Products run on the bit-serial multiplier. A baby or giant step hashes
// the value, reads its slot and probes past other values; a product then
// follows, but a giant-step match ends the search. A search runs s baby and
// up to s giant steps, s = ceil(sqrt(modulus)). HASH_SLOTS is a power
// of two. After reset, and once every 255 queries, the table tags are
// swept over all HASH_SLOTS slots. The receiver cannot stall results.
module discrete_log_bsgs_unit #(
  parameter int unsigned MODULUS_BITS = 32,
  parameter int unsigned BABY_STEPS   = 65536,
  parameter int unsigned HASH_SLOTS   = 131072
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [dlb_pkg::WORD_W-1:0] base_i,
  input  logic [dlb_pkg::WORD_W-1:0] target_i,
  output logic                       done_o,
  output logic                       found_o,
  output logic [dlb_pkg::WORD_W-1:0] exponent_o,
  input  logic                       cfg_we_i,
  input  logic [dlb_pkg::WORD_W-1:0] cfg_wdata_i
);
  import dlb_pkg::*;

  localparam int unsigned SW = $clog2(HASH_SLOTS);
  localparam int unsigned IW = $clog2(BABY_STEPS);
  localparam int unsigned DW = EPOCH_W + IW + WORD_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(HASH_SLOTS - 1);

  dlb_state_e state_q, state_d;
  logic [MODULUS_BITS-1:0] mod_q;
  logic [WORD_W-1:0] m32;
  logic              pend_q, pend_d;
  logic [WORD_W-1:0] base_q, base_d, tgt_q, tgt_d, bq_q, bq_d, yq_q, yq_d;
  logic [WORD_W-1:0] p_q, p_d, giant_q, giant_d, pres_q, pres_d;
  logic [WORD_W-1:0] pbase_q, pbase_d, pexp_q, pexp_d;
  logic [WORD_W-1:0] exp_q, exp_d;
  logic [STEP_W-1:0] lo_q, lo_d, hi_q, hi_d, s_q, s_d, i_q, i_d, mid;
  logic [STEP_W:0]   lohi;
  logic [2*STEP_W-1:0] sq, isprod;
  logic [WORD_W-1:0] hwide;
  logic [SW-1:0]     h_q, h_d, caddr_q, caddr_d;
  logic [SW:0]       n_q, n_d;
  logic [IW-1:0]     j_q, j_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic              look_q, look_d, pw2_q, pw2_d, clr_ret_q, clr_ret_d;
  logic              found_q, found_d;

  logic              mm_go, mm_done;
  logic [WORD_W-1:0] mm_a, mm_b, mm_m, mm_res;

  logic              tb_we;
  logic [SW-1:0]     tb_addr;
  logic [DW-1:0]     tb_wdata, tb_rdata;
  logic [EPOCH_W-1:0] rd_tag;
  logic [IW-1:0]     rd_idx;
  logic [WORD_W-1:0] rd_val;

  assign m32    = WORD_W'(mod_q);
  assign rd_tag = tb_rdata[DW-1 -: EPOCH_W];
  assign rd_idx = tb_rdata[WORD_W +: IW];
  assign rd_val = tb_rdata[WORD_W-1:0];
  assign lohi   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid    = lohi[STEP_W:1];
  assign sq     = (2*STEP_W)'(mid) * (2*STEP_W)'(mid);
  assign isprod = (2*STEP_W)'(i_q) * (2*STEP_W)'(s_q);
  assign hwide  = p_q * HASH_MULT;

  dlb_modmul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mm_go),
    .a_i    (mm_a),
    .b_i    (mm_b),
    .m_i    (mm_m),
    .done_o (mm_done),
    .res_o  (mm_res)
  );

  dlb_table #(
    .DEPTH (HASH_SLOTS),
    .AW    (SW),
    .DW    (DW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tb_we),
    .addr_i  (tb_addr),
    .wdata_i (tb_wdata),
    .rdata_o (tb_rdata)
  );

  always_comb begin
    mm_a = 32'd1;
    mm_b = p_q;
    mm_m = m32;
    case (state_q)
      ST_REDB:  mm_b = base_q;
      ST_REDY:  mm_b = tgt_q;
      ST_BMUL: begin
        mm_a = p_q;
        mm_b = bq_q;
      end
      ST_PWMUL: begin
        mm_a = pres_q;
        mm_b = pbase_q;
      end
      ST_PWSQ: begin
        mm_a = pbase_q;
        mm_b = pbase_q;
      end
      ST_GMUL: begin
        mm_a = p_q;
        mm_b = giant_q;
      end
      default: mm_a = 32'd1;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    pend_d    = pend_q;
    base_d    = base_q;
    tgt_d     = tgt_q;
    bq_d      = bq_q;
    yq_d      = yq_q;
    p_d       = p_q;
    giant_d   = giant_q;
    pres_d    = pres_q;
    pbase_d   = pbase_q;
    pexp_d    = pexp_q;
    exp_d     = exp_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    s_d       = s_q;
    i_d       = i_q;
    h_d       = h_q;
    caddr_d   = caddr_q;
    n_d       = n_q;
    j_d       = j_q;
    epoch_d   = epoch_q;
    look_d    = look_q;
    pw2_d     = pw2_q;
    clr_ret_d = clr_ret_q;
    found_d   = found_q;
    mm_go     = 1'b0;
    tb_we     = 1'b0;
    tb_addr   = h_q;
    tb_wdata  = {epoch_q, i_q[IW-1:0], p_q};

    case (state_q)
      ST_CLEAR: begin
        tb_we    = 1'b1;
        tb_addr  = caddr_q;
        tb_wdata = '0;
        caddr_d  = caddr_q + SW'(1);
        if (caddr_q == LAST_SLOT) begin
          if (clr_ret_q) begin
            epoch_d = EPOCH_W'(1);
            p_d     = 32'd1;
            i_d     = '0;
            look_d  = 1'b0;
            state_d = ST_HPROD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        if (start) begin
          base_d  = base_i;
          tgt_d   = target_i;
          found_d = 1'b0;
          exp_d   = '0;
          state_d = (m32 < 32'd2) ? ST_OUT : ST_REDB;
        end
      end
      ST_REDB: begin
        if (!pend_q) begin
          mm_go  = 1'b1;
          pend_d = 1'b1;
        end else if (mm_done) begin
          pend_d  = 1'b0;
          bq_d    = mm_res;
          state_d = ST_REDY;
        end
      end
      ST_REDY: begin
        if (!pend_q) begin
          mm_go  = 1'b1;
          pend_d = 1'b1;
        end else if (mm_done) begin
          pend_d = 1'b0;
          yq_d   = mm_res;
          if (bq_q == '0) begin
            if (mm_res == '0) begin
              found_d = 1'b1;
              exp_d   = 32'd1;
            end else if (mm_res == 32'd1) begin
              found_d = 1'b1;
            end
            state_d = ST_OUT;
          end else begin
            lo_d    = '0;
            hi_d    = SEARCH_HI;
            state_d = ST_SRCH;
          end
        end
      end
      ST_SRCH: begin
        if (lo_q < hi_q) begin
          if (sq >= (2*STEP_W)'(m32)) begin
            hi_d = mid;
          end else begin
            lo_d = mid + STEP_W'(1);
          end
        end else begin
          s_d     = (lo_q > STEP_W'(BABY_STEPS)) ? STEP_W'(BABY_STEPS) : lo_q;
          state_d = ST_EPOCH;
        end
      end
      ST_EPOCH: begin
        if (epoch_q == '1) begin
          caddr_d   = '0;
          clr_ret_d = 1'b1;
          state_d   = ST_CLEAR;
        end else begin
          epoch_d = epoch_q + EPOCH_W'(1);
          p_d     = 32'd1;
          i_d     = '0;
          look_d  = 1'b0;
          state_d = ST_HPROD;
        end
      end
      ST_HPROD: begin
        h_d     = hwide[SW-1:0];
        n_d     = '0;
        state_d = ST_RD;
      end
      ST_RD: state_d = ST_CHK;
      ST_CHK: begin
        if (rd_tag != epoch_q) begin
          tb_we   = !look_q;
          state_d = look_q ? ST_GMUL : ST_BMUL;
        end else if (rd_val == p_q) begin
          j_d     = rd_idx;
          state_d = look_q ? ST_EXP : ST_BMUL;
        end else if (n_q == (SW+1)'(HASH_SLOTS - 1)) begin
          state_d = look_q ? ST_GMUL : ST_BMUL;
        end else begin
          h_d     = (h_q == LAST_SLOT) ? '0 : h_q + SW'(1);
          n_d     = n_q + (SW+1)'(1);
          state_d = ST_RD;
        end
      end
      ST_BMUL: begin
        if (!pend_q) begin
          mm_go  = 1'b1;
          pend_d = 1'b1;
        end else if (mm_done) begin
          pend_d = 1'b0;
          p_d    = mm_res;
          i_d    = i_q + STEP_W'(1);
          if (i_q + STEP_W'(1) == s_q) begin
            pbase_d = bq_q;
            pexp_d  = m32 - 32'd2;
            pres_d  = 32'd1;
            pw2_d   = 1'b0;
            state_d = ST_PWCHK;
          end else begin
            state_d = ST_HPROD;
          end
        end
      end
      ST_PWCHK: begin
        if (pexp_q == '0) begin
          if (!pw2_q) begin
            pbase_d = pres_q;
            pexp_d  = WORD_W'(s_q);
            pres_d  = 32'd1;
            pw2_d   = 1'b1;
          end else begin
            giant_d = pres_q;
            p_d     = yq_q;
            i_d     = '0;
            look_d  = 1'b1;
            state_d = ST_HPROD;
          end
        end else begin
          state_d = pexp_q[0] ? ST_PWMUL : ST_PWSQ;
        end
      end
      ST_PWMUL: begin
        if (!pend_q) begin
          mm_go  = 1'b1;
          pend_d = 1'b1;
        end else if (mm_done) begin
          pend_d  = 1'b0;
          pres_d  = mm_res;
          state_d = ST_PWSQ;
        end
      end
      ST_PWSQ: begin
        if (!pend_q) begin
          mm_go  = 1'b1;
          pend_d = 1'b1;
        end else if (mm_done) begin
          pend_d  = 1'b0;
          pbase_d = mm_res;
          pexp_d  = {1'b0, pexp_q[WORD_W-1:1]};
          state_d = ST_PWCHK;
        end
      end
      ST_GMUL: begin
        if (!pend_q) begin
          mm_go  = 1'b1;
          pend_d = 1'b1;
        end else if (mm_done) begin
          pend_d = 1'b0;
          p_d    = mm_res;
          i_d    = i_q + STEP_W'(1);
          if (i_q + STEP_W'(1) == s_q) begin
            found_d = 1'b0;
            exp_d   = '0;
            state_d = ST_OUT;
          end else begin
            state_d = ST_HPROD;
          end
        end
      end
      ST_EXP: begin
        found_d = 1'b1;
        exp_d   = isprod[WORD_W-1:0] + WORD_W'(j_q);
        state_d = ST_OUT;
      end
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      mod_q     <= MODULUS_BITS'(2);
      pend_q    <= 1'b0;
      caddr_q   <= '0;
      epoch_q   <= '0;
      clr_ret_q <= 1'b0;
      found_q   <= 1'b0;
      exp_q     <= '0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      caddr_q   <= caddr_d;
      epoch_q   <= epoch_d;
      clr_ret_q <= clr_ret_d;
      found_q   <= found_d;
      exp_q     <= exp_d;
      if (cfg_we_i) begin
        mod_q <= cfg_wdata_i[MODULUS_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    tgt_q   <= tgt_d;
    bq_q    <= bq_d;
    yq_q    <= yq_d;
    p_q     <= p_d;
    giant_q <= giant_d;
    pres_q  <= pres_d;
    pbase_q <= pbase_d;
    pexp_q  <= pexp_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    s_q     <= s_d;
    i_q     <= i_d;
    h_q     <= h_d;
    n_q     <= n_d;
    j_q     <= j_d;
    look_q  <= look_d;
    pw2_q   <= pw2_d;
  end

  assign busy       = (state_q != ST_IDLE);
  assign done_o     = (state_q == ST_OUT);
  assign found_o    = found_q;
  assign exponent_o = exp_q;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result strobe while idle");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("query transfer not taken");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !found_o |-> exponent_o == '0) else $error("nonzero exponent on miss");
  a_mul_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_done |-> pend_q) else $error("product with no request");

endmodule
